// ----- rtl/rxs_pkg.sv -----
// ----------------------------------------------------------------------------
// rxs_pkg
// Shared sizes and record types for the record exchange sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rxs_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int KEY_W       = 32;
  localparam int TAG_W       = 6;
  localparam int REC_W       = KEY_W + TAG_W;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
  } rxs_rec_t;

  typedef struct packed {
    rxs_rec_t rec;
    logic     last;
    logic     ovf;
  } rxs_item_t;

endpackage

// ----- rtl/rxs_ram.sv -----
// ----------------------------------------------------------------------------
// rxs_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rxs_ram #(
  parameter int Depth = 64,
  parameter int Width = 38
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rxs_seq.sv -----
// ----------------------------------------------------------------------------
// rxs_seq
// Loads records into the store, runs the exchange sort by read-modify-write
// through the RAM, then streams the sorted records out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rxs_seq
  import rxs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic        [TAG_W-1:0] in_tag,
  input  logic                    in_last,
  output logic                    item_valid,
  input  logic                    item_ready,
  output rxs_item_t               item
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_I,
    S_LD_I,
    S_SCAN,
    S_WR_I,
    S_EM_RD,
    S_EM_WAIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] e_r, e_nxt;
  logic [IDX_W-1:0] pend_r, pend_nxt;
  rxs_rec_t         cur_r, cur_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr;
  rxs_rec_t         wdata;
  logic             ren;
  logic [IDX_W-1:0] raddr;
  logic [REC_W-1:0] rdata_raw;
  rxs_rec_t         rdata;
  rxs_rec_t         in_rec;
  logic             em_last;

  assign rdata      = rxs_rec_t'(rdata_raw);
  assign in_rec.key = in_key;
  assign in_rec.tag = in_tag;
  assign in_ready   = (state_r == S_LOAD);
  assign em_last    = ((e_r + CNT_W'(1)) == cnt_r);

  assign item.rec  = rdata;
  assign item.last = em_last;
  assign item.ovf  = drop_r;

  rxs_ram #(
    .Depth(MAX_RECORDS),
    .Width(REC_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .ren  (ren),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    drop_nxt   = drop_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    e_nxt      = e_r;
    pend_nxt   = pend_r;
    cur_nxt    = cur_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = in_rec;
    ren        = 1'b0;
    raddr      = '0;
    item_valid = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CNT_W'(MAX_RECORDS)) begin
            we      = 1'b1;
            waddr   = cnt_r[IDX_W-1:0];
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt = '0;
            e_nxt = '0;
            if (cnt_nxt < CNT_W'(2)) begin
              state_nxt = S_EM_RD;
            end else begin
              state_nxt = S_RD_I;
            end
          end
        end
      end
      S_RD_I: begin
        ren       = 1'b1;
        raddr     = i_r[IDX_W-1:0];
        j_nxt     = i_r + CNT_W'(1);
        state_nxt = S_LD_I;
      end
      S_LD_I: begin
        cur_nxt   = rdata;
        ren       = 1'b1;
        raddr     = j_r[IDX_W-1:0];
        pend_nxt  = j_r[IDX_W-1:0];
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if ($signed(cur_r.key) > $signed(rdata.key)) begin
          we      = 1'b1;
          waddr   = pend_r;
          wdata   = cur_r;
          cur_nxt = rdata;
        end
        if (j_r < cnt_r) begin
          ren      = 1'b1;
          raddr    = j_r[IDX_W-1:0];
          pend_nxt = j_r[IDX_W-1:0];
          j_nxt    = j_r + CNT_W'(1);
        end else begin
          state_nxt = S_WR_I;
        end
      end
      S_WR_I: begin
        we    = 1'b1;
        waddr = i_r[IDX_W-1:0];
        wdata = cur_r;
        i_nxt = i_r + CNT_W'(1);
        if ((i_r + CNT_W'(2)) < cnt_r) begin
          state_nxt = S_RD_I;
        end else begin
          state_nxt = S_EM_RD;
        end
      end
      S_EM_RD: begin
        ren       = 1'b1;
        raddr     = e_r[IDX_W-1:0];
        state_nxt = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        item_valid = 1'b1;
        if (item_ready) begin
          e_nxt = e_r + CNT_W'(1);
          if (em_last) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      e_r     <= '0;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      e_r     <= e_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond capacity");

  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (we && ren) |-> (waddr != raddr))
    else $error("read and write hit the same entry");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid |-> (e_r < cnt_r))
    else $error("emit index past stored set");

  a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input still taken after last record");

endmodule

// ----- rtl/record_exchange_sort.sv -----
// ----------------------------------------------------------------------------
// record_exchange_sort
// Collects keyed records, sorts them ascending by signed key with an exchange
// sort, and streams them out in order.
//
//   channel | ports                                   | dir
//   --------+-----------------------------------------+----
//   input   | in_valid/in_ready, in_record_key,       | in
//           | in_record_tag, in_last_record           |
//   result  | out_valid/out_ready, out_sorted_key,    | out
//           | out_sorted_tag, out_end_of_run,         |
//           | out_overflow                            |
//
// Loading accepts items while in_ready is high. After the last item of a set
// the sort runs through the one-port-read RAM (one compare per cycle), then
// each result is read from the RAM and handed off to the output register.
// Input is held off from the last item until the final result leaves the
// sequencer. Reset is synchronous, active low; RAM contents are not cleared.
// Stalls on the result side hold the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module record_exchange_sort
  import rxs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [KEY_W-1:0] in_record_key,
  input  logic        [TAG_W-1:0] in_record_tag,
  input  logic                    in_last_record,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [KEY_W-1:0] out_sorted_key,
  output logic        [TAG_W-1:0] out_sorted_tag,
  output logic                    out_end_of_run,
  output logic                    out_overflow
);

  logic      item_valid;
  logic      item_ready;
  rxs_item_t item;
  logic      out_valid_r;
  rxs_item_t out_item_r;

  rxs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_key    (in_record_key),
    .in_tag    (in_record_tag),
    .in_last   (in_last_record),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item)
  );

  assign item_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_ready) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      out_item_r <= item;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_item_r.rec.key;
  assign out_sorted_tag = out_item_r.rec.tag;
  assign out_end_of_run = out_item_r.last;
  assign out_overflow   = out_item_r.ovf;

endmodule

// ----- test/record_exchange_sort_test.sv -----
// ----------------------------------------------------------------------------
// record_exchange_sort_test
// Streams record sets into the sorter, including single-record sets, tied and
// extreme keys, a set that exactly fills the store and sets that overflow it.
// A local exchange sort predicts every result, which is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module record_exchange_sort_test;
  import rxs_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 350;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
    logic                    last;
    bit                      drain_first;
  } record_item_t;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
    logic                    end_run;
    logic                    dropped;
  } sorted_entry_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [KEY_W-1:0] in_record_key = '0;
  logic        [TAG_W-1:0] in_record_tag = '0;
  logic                    in_last_record = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [KEY_W-1:0] out_sorted_key;
  logic        [TAG_W-1:0] out_sorted_tag;
  logic                    out_end_of_run;
  logic                    out_overflow;

  record_item_t  pending_records[$];
  sorted_entry_t sorted_due[$];
  record_item_t  offered;
  sorted_entry_t due_entry;

  logic signed [KEY_W-1:0] held_key[MAX_RECORDS];
  logic        [TAG_W-1:0] held_tag[MAX_RECORDS];
  int                      held_count = 0;
  bit                      held_dropped = 1'b0;

  int accepted_items = 0;
  int total_items = 1;
  int fault_count = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int sender_gap_pct;
  int receiver_gap_pct;

  record_exchange_sort u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_record_key  (in_record_key),
    .in_record_tag  (in_record_tag),
    .in_last_record (in_last_record),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sorted_key (out_sorted_key),
    .out_sorted_tag (out_sorted_tag),
    .out_end_of_run (out_end_of_run),
    .out_overflow   (out_overflow)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always_comb begin
    if (accepted_items < total_items / 3) begin
      sender_gap_pct   = 25;
      receiver_gap_pct = 78;
    end else if (accepted_items < 2 * total_items / 3) begin
      sender_gap_pct   = 78;
      receiver_gap_pct = 25;
    end else begin
      sender_gap_pct   = 0;
      receiver_gap_pct = 0;
    end
  end

  task automatic push_record(input logic signed [KEY_W-1:0] key, input int tag,
                             input bit last, input bit drain_first);
    record_item_t r;
    r.key         = key;
    r.tag         = tag[TAG_W-1:0];
    r.last        = last;
    r.drain_first = drain_first;
    pending_records.push_back(r);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom;
      2:       return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  // store the record, and on the last one sort the set and queue its results
  task automatic store_and_sort(input record_item_t r);
    logic signed [KEY_W-1:0] tk;
    logic        [TAG_W-1:0] tt;
    sorted_entry_t           e;
    if (held_count < MAX_RECORDS) begin
      held_key[held_count] = r.key;
      held_tag[held_count] = r.tag;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (r.last) begin
      for (int i = 0; i + 1 < held_count; i++) begin
        for (int j = i + 1; j < held_count; j++) begin
          if (held_key[i] > held_key[j]) begin
            tk = held_key[i];
            tt = held_tag[i];
            held_key[i] = held_key[j];
            held_tag[i] = held_tag[j];
            held_key[j] = tk;
            held_tag[j] = tt;
          end
        end
      end
      for (int i = 0; i < held_count; i++) begin
        e.key     = held_key[i];
        e.tag     = held_tag[i];
        e.end_run = (i + 1 == held_count);
        e.dropped = held_dropped;
        sorted_due.push_back(e);
      end
      held_count   = 0;
      held_dropped = 1'b0;
    end
  endtask

  task automatic report_fault(input string msg);
    if (fault_count < 10) $display("%s", msg);
    fault_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_record_key  <= '0;
      in_record_tag  <= '0;
      in_last_record <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        store_and_sort(offered);
        accepted_items <= accepted_items + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_records.size() > 0 &&
            !(pending_records[0].drain_first && sorted_due.size() > 0) &&
            $urandom_range(0, 99) >= sender_gap_pct) begin
          offered = pending_records.pop_front();
          in_valid       <= 1'b1;
          in_record_key  <= offered.key;
          in_record_tag  <= offered.tag;
          in_last_record <= offered.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && out_valid && in_valid && accepted_items > total_items / 4) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sorted_due.size() == 0) begin
        report_fault($sformatf("unexpected result: key %0d tag %0d end %0b ovf %0b",
                               out_sorted_key, out_sorted_tag, out_end_of_run,
                               out_overflow));
      end else begin
        due_entry = sorted_due.pop_front();
        if (out_sorted_key !== due_entry.key || out_sorted_tag !== due_entry.tag ||
            out_end_of_run !== due_entry.end_run || out_overflow !== due_entry.dropped)
          report_fault($sformatf(
            "mismatch: expected key %0d tag %0d end %0b ovf %0b, got key %0d tag %0d end %0b ovf %0b",
            due_entry.key, due_entry.tag, due_entry.end_run, due_entry.dropped,
            out_sorted_key, out_sorted_tag, out_end_of_run, out_overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL record_exchange_sort");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int big_sizes[3];
    int big_next;
    int random_count;
    int set_size;
    big_sizes    = '{64, 65, 70};
    big_next     = 0;
    random_count = 0;

    push_record(32'sh8000_0000, 0, 1'b1, 1'b0);
    push_record(32'sh7FFF_FFFF, 63, 1'b0, 1'b0);
    push_record(32'sh8000_0000, 1, 1'b0, 1'b0);
    push_record(32'sd0, 2, 1'b0, 1'b0);
    push_record(-32'sd1, 3, 1'b0, 1'b0);
    push_record(32'sd1, 4, 1'b0, 1'b0);
    push_record(32'sh7FFF_FFFF, 5, 1'b1, 1'b0);
    push_record(32'sd5, 10, 1'b0, 1'b1);
    push_record(32'sd5, 11, 1'b0, 1'b0);
    push_record(32'sd5, 12, 1'b1, 1'b0);
    push_record(32'sd100, 20, 1'b0, 1'b0);
    push_record(32'sd50, 21, 1'b0, 1'b0);
    push_record(32'sd0, 22, 1'b0, 1'b0);
    push_record(-32'sd50, 23, 1'b1, 1'b0);
    push_record(-32'sd2, 40, 1'b0, 1'b0);
    push_record(32'sd3, 41, 1'b1, 1'b0);

    for (int s = 0; random_count < RANDOM_ITEMS; s++) begin
      if (s % 6 == 3 && big_next < 3) begin
        set_size = big_sizes[big_next];
        big_next++;
      end else begin
        set_size = $urandom_range(1, 10);
      end
      for (int k = 0; k < set_size; k++)
        push_record(pick_key(), $urandom_range(0, 63), k == set_size - 1,
                    k == 0 && s % 5 == 0);
      random_count += set_size;
    end
    total_items = pending_records.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_records.size() > 0 || in_valid || sorted_due.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (fault_count == 0) begin
      $display("PASS record_exchange_sort");
    end else begin
      $display("FAIL record_exchange_sort");
    end
    $finish;
  end

endmodule

// ----- record_exchange_sort.f -----
rtl/rxs_pkg.sv
rtl/rxs_ram.sv
rtl/rxs_seq.sv
rtl/record_exchange_sort.sv
test/record_exchange_sort_test.sv
